>>> rtl/reverse_cuthill_mckee_order_core_assert.svh
// Assertion macros shared by the ordering core.
`ifndef REVERSE_CUTHILL_MCKEE_ORDER_CORE_ASSERT_SVH
`define REVERSE_CUTHILL_MCKEE_ORDER_CORE_ASSERT_SVH

// Same-cycle implication.
`define RCM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rcm assertion failed");

// Next-cycle implication.
`define RCM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rcm assertion failed");

`endif

>>> rtl/rcm_pkg.sv
// Package: codes and sequencer states of the ordering core.
`timescale 1ns / 1ps
`default_nettype none
package rcm_pkg;

    localparam int CMD_W    = 2;
    localparam int NODE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 9;

    localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RUN  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NORES = 2'd3;

    localparam logic REG_NODE_COUNT = 1'b0;
    localparam logic REG_PINNED     = 1'b1;

    typedef enum logic [5:0] {
        S_IDLE, S_READ, S_CLR,
        S_CNT_RD, S_CNT_R, S_CNT_WR, S_CNT_WC,
        S_PFX_RD, S_PFX_WR,
        S_FIL_RD, S_FIL_R, S_FIL_WR, S_FIL_WC,
        S_SRT_RD, S_SRT_K, S_SRT_CMP, S_SRT_PUT,
        S_SEED_RD, S_SEED_V, S_SEED_CHK,
        S_NODE_RD, S_NODE_RS0, S_NODE_RS1, S_NODE_RS2,
        S_NB_RD, S_NB_V, S_NB_CHK, S_NB_DEG,
        S_WS_A, S_WS_V, S_WS_CMP, S_WS_PUT,
        S_OUT_RD, S_OUT_WR
    } state_t;

endpackage
`default_nettype wire

>>> rtl/reverse_cuthill_mckee_order_core.sv
// Top level: reverse Cuthill-McKee ordering engine with edge store and result tables.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//  Command channel: a beat is taken at a clock edge with start high and busy low.
//  cmd LOAD stores one (row_index, col_index) entry; cmd RUN orders the first
//  node_count - pinned_count nodes; cmd READ returns perm_node / inverse_pos at
//  position. Every command gives exactly one result beat on status, perm_node and
//  inverse_pos, marked by result_valid for one cycle; the receiver cannot stall.
//  Config channel: cfg_valid/cfg_ready (ready always high), cfg_index 0 writes
//  node_count, 1 writes pinned_count. Write only while the block is idle.
// Timing:
//  LOAD, bad RUN, early READ and cmd 3 answer the cycle after the beat; a new
//  beat can follow at once. A READ answers through state S_READ: the result
//  tables are memories with a registered read. A RUN is run by one sequencer
//  over memories with one write and one registered read port each: a clear of
//  all MAX_NODES entries, two passes over the edge store (degree count, then
//  adjacency fill), prefix sums over the active nodes, the degree sort, a scan
//  of seed candidates, the breadth-first walk with an insertion sort of each
//  node's new neighbors, then a write of the result tables for every index.
// Reset: edge store empty, no result, node_count 256, pinned_count 0.
module reverse_cuthill_mckee_order_core
    import rcm_pkg::*;
#(
    parameter int MAX_NODES = 256,
    parameter int MAX_EDGES = 1024
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [CMD_W-1:0]    cmd,
    input  wire logic [NODE_W-1:0]   row_index,
    input  wire logic [NODE_W-1:0]   col_index,
    input  wire logic [NODE_W-1:0]   position,
    output logic                     result_valid,
    output logic [STATUS_W-1:0]      status,
    output logic [NODE_W-1:0]        perm_node,
    output logic [NODE_W-1:0]        inverse_pos,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_index,
    input  wire logic [CFG_W-1:0]    cfg_data
);

`include "reverse_cuthill_mckee_order_core_assert.svh"

    localparam int NI_W  = $clog2(MAX_NODES);
    localparam int CNT_W = $clog2(MAX_NODES + 1);
    localparam int EI_W  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EC_W  = $clog2(MAX_EDGES + 1);
    localparam int NB_W  = $clog2(2 * MAX_EDGES);
    localparam int RS_W  = $clog2(2 * MAX_EDGES + 1);
    localparam int PW    = NI_W + RS_W;

    // ---------------- memories ----------------
    logic [2*NODE_W-1:0] edge_mem [MAX_EDGES];
    logic [RS_W-1:0]     deg_mem  [MAX_NODES];
    logic [RS_W-1:0]     rs_mem   [MAX_NODES+1];
    logic [RS_W-1:0]     fill_mem [MAX_NODES];
    logic [NI_W-1:0]     nbr_mem  [2*MAX_EDGES];
    logic                vis_mem  [MAX_NODES];
    logic [PW-1:0]       srt_mem  [MAX_NODES];
    logic [PW-1:0]       walk_mem [MAX_NODES];
    logic [NI_W-1:0]     new_mem  [MAX_NODES];
    logic [NI_W-1:0]     inv_mem  [MAX_NODES];

    logic                edge_we;
    logic [EI_W-1:0]     edge_wa, edge_ra;
    logic [2*NODE_W-1:0] edge_wd, edge_rd;
    logic                deg_we;
    logic [NI_W-1:0]     deg_wa, deg_ra;
    logic [RS_W-1:0]     deg_wd, deg_rd;
    logic                rs_we;
    logic [CNT_W-1:0]    rs_wa, rs_ra;
    logic [RS_W-1:0]     rs_wd, rs_rd;
    logic                fill_we;
    logic [NI_W-1:0]     fill_wa, fill_ra;
    logic [RS_W-1:0]     fill_wd, fill_rd;
    logic                nbr_we;
    logic [NB_W-1:0]     nbr_wa, nbr_ra;
    logic [NI_W-1:0]     nbr_wd, nbr_rd;
    logic                vis_we, vis_wd, vis_rd;
    logic [NI_W-1:0]     vis_wa, vis_ra;
    logic                srt_we;
    logic [NI_W-1:0]     srt_wa, srt_ra;
    logic [PW-1:0]       srt_wd, srt_rd;
    logic                walk_we;
    logic [NI_W-1:0]     walk_wa, walk_ra;
    logic [PW-1:0]       walk_wd, walk_rd;
    logic                new_we;
    logic [NI_W-1:0]     new_wa, new_wd, new_rd;
    logic                inv_we;
    logic [NI_W-1:0]     inv_wa, inv_wd, inv_rd;
    logic [NI_W-1:0]     tbl_ra;

    always_ff @(posedge clk)
    begin
        if (edge_we) edge_mem[edge_wa] <= edge_wd;
        edge_rd <= edge_mem[edge_ra];
    end
    always_ff @(posedge clk)
    begin
        if (deg_we) deg_mem[deg_wa] <= deg_wd;
        deg_rd <= deg_mem[deg_ra];
    end
    always_ff @(posedge clk)
    begin
        if (rs_we) rs_mem[rs_wa] <= rs_wd;
        rs_rd <= rs_mem[rs_ra];
    end
    always_ff @(posedge clk)
    begin
        if (fill_we) fill_mem[fill_wa] <= fill_wd;
        fill_rd <= fill_mem[fill_ra];
    end
    always_ff @(posedge clk)
    begin
        if (nbr_we) nbr_mem[nbr_wa] <= nbr_wd;
        nbr_rd <= nbr_mem[nbr_ra];
    end
    always_ff @(posedge clk)
    begin
        if (vis_we) vis_mem[vis_wa] <= vis_wd;
        vis_rd <= vis_mem[vis_ra];
    end
    always_ff @(posedge clk)
    begin
        if (srt_we) srt_mem[srt_wa] <= srt_wd;
        srt_rd <= srt_mem[srt_ra];
    end
    always_ff @(posedge clk)
    begin
        if (walk_we) walk_mem[walk_wa] <= walk_wd;
        walk_rd <= walk_mem[walk_ra];
    end
    always_ff @(posedge clk)
    begin
        if (new_we) new_mem[new_wa] <= new_wd;
        new_rd <= new_mem[tbl_ra];
    end
    always_ff @(posedge clk)
    begin
        if (inv_we) inv_mem[inv_wa] <= inv_wd;
        inv_rd <= inv_mem[tbl_ra];
    end

    // ---------------- registers ----------------
    state_t              state_reg, state_next;
    logic [CFG_W-1:0]    nc_reg, nc_next;
    logic [NODE_W-1:0]   pc_reg, pc_next;
    logic [EC_W-1:0]     ecnt_reg, ecnt_next;
    logic                ready_reg, ready_next;
    logic [CNT_W-1:0]    dim_reg, dim_next;
    logic [EC_W-1:0]     k_reg, k_next;
    logic [CNT_W-1:0]    i_reg, i_next;
    logic [CNT_W-1:0]    j_reg, j_next;
    logic [CNT_W-1:0]    z_reg, z_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    ii_reg, ii_next;
    logic [CNT_W-1:0]    a_reg, a_next;
    logic [CNT_W-1:0]    first_reg, first_next;
    logic [RS_W-1:0]     jj_reg, jj_next;
    logic [RS_W-1:0]     jend_reg, jend_next;
    logic [RS_W-1:0]     acc_reg, acc_next;
    logic [NI_W-1:0]     vn_reg, vn_next;
    logic [RS_W-1:0]     vd_reg, vd_next;
    logic [NI_W-1:0]     r_reg, r_next;
    logic [NI_W-1:0]     c_reg, c_next;
    logic [NODE_W-1:0]   pos_reg, pos_next;
    logic                rv_reg, rv_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [NODE_W-1:0]   pn_reg, pn_next;
    logic [NODE_W-1:0]   ip_reg, ip_next;

    // ---------------- shared conditions ----------------
    logic              acc_item, cfg_bad, e_ok, srt_less, ws_less;
    logic [NODE_W-1:0] e_r, e_c;
    logic [CNT_W-1:0]  jm1, jm2, dmi;

    assign acc_item = start && !busy;
    assign cfg_bad  = (nc_reg == '0) || (32'(nc_reg) > MAX_NODES) || ({1'b0, pc_reg} >= nc_reg);
    assign e_r      = edge_rd[2*NODE_W-1:NODE_W];
    assign e_c      = edge_rd[NODE_W-1:0];
    assign e_ok     = (32'(e_r) < 32'(dim_reg)) && (32'(e_c) < 32'(dim_reg)) && (e_r != e_c);
    assign srt_less = vd_reg < srt_rd[RS_W-1:0];
    assign ws_less  = vd_reg < walk_rd[RS_W-1:0];
    assign jm1      = j_reg - CNT_W'(1);
    assign jm2      = j_reg - CNT_W'(2);
    assign dmi      = dim_reg - i_reg - CNT_W'(1);
    assign tbl_ra   = NI_W'(position);

    // index one below a counter, narrowed to an address
    function automatic logic [NI_W-1:0] jm1_of_i(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] t;
        t = v - CNT_W'(1);
        return t[NI_W-1:0];
    endfunction

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (acc_item)
                begin
                    if (cmd == CMD_RUN && !cfg_bad) state_next = S_CLR;
                    else if (cmd == CMD_READ && ready_reg) state_next = S_READ;
                end
            S_READ:     state_next = S_IDLE;
            S_CLR:      if (32'(i_reg) == MAX_NODES - 1) state_next = S_CNT_RD;
            S_CNT_RD:   state_next = (k_reg < ecnt_reg) ? S_CNT_R : S_PFX_RD;
            S_CNT_R:    state_next = e_ok ? S_CNT_WR : S_CNT_RD;
            S_CNT_WR:   state_next = S_CNT_WC;
            S_CNT_WC:   state_next = S_CNT_RD;
            S_PFX_RD:   state_next = (i_reg < dim_reg) ? S_PFX_WR : S_FIL_RD;
            S_PFX_WR:   state_next = S_PFX_RD;
            S_FIL_RD:   state_next = (k_reg < ecnt_reg) ? S_FIL_R : S_SRT_RD;
            S_FIL_R:    state_next = e_ok ? S_FIL_WR : S_FIL_RD;
            S_FIL_WR:   state_next = S_FIL_WC;
            S_FIL_WC:   state_next = S_FIL_RD;
            S_SRT_RD:   state_next = (i_reg < dim_reg) ? S_SRT_K : S_SEED_RD;
            S_SRT_K:    state_next = (i_reg == '0) ? S_SRT_RD : S_SRT_CMP;
            S_SRT_CMP:
                if (!srt_less) state_next = S_SRT_RD;
                else if (jm1 == '0) state_next = S_SRT_PUT;
            S_SRT_PUT:  state_next = S_SRT_RD;
            S_SEED_RD:  state_next = (z_reg < dim_reg) ? S_SEED_V : S_OUT_RD;
            S_SEED_V:   state_next = S_SEED_CHK;
            S_SEED_CHK: state_next = vis_rd ? S_SEED_RD : S_NODE_RD;
            S_NODE_RD:  state_next = (ii_reg < cnt_reg) ? S_NODE_RS0 : S_SEED_RD;
            S_NODE_RS0: state_next = S_NODE_RS1;
            S_NODE_RS1: state_next = S_NODE_RS2;
            S_NODE_RS2: state_next = S_NB_RD;
            S_NB_RD:    state_next = (jj_reg < jend_reg) ? S_NB_V : S_WS_A;
            S_NB_V:     state_next = S_NB_CHK;
            S_NB_CHK:   state_next = vis_rd ? S_NB_RD : S_NB_DEG;
            S_NB_DEG:   state_next = S_NB_RD;
            S_WS_A:     state_next = (a_reg < cnt_reg) ? S_WS_V : S_NODE_RD;
            S_WS_V:     state_next = S_WS_CMP;
            S_WS_CMP:
                if (!ws_less) state_next = S_WS_A;
                else if (!(jm1 > first_reg)) state_next = S_WS_PUT;
            S_WS_PUT:   state_next = S_WS_A;
            S_OUT_RD:
                if (32'(i_reg) == MAX_NODES) state_next = S_IDLE;
                else if (i_reg < dim_reg) state_next = S_OUT_WR;
            S_OUT_WR:   state_next = S_OUT_RD;
            default:    state_next = S_IDLE;
        endcase
    end

    // ---------------- datapath and memory control ----------------
    always_comb
    begin
        nc_next = nc_reg;       pc_next = pc_reg;
        ecnt_next = ecnt_reg;   ready_next = ready_reg;
        dim_next = dim_reg;     k_next = k_reg;
        i_next = i_reg;         j_next = j_reg;
        z_next = z_reg;         cnt_next = cnt_reg;
        ii_next = ii_reg;       a_next = a_reg;
        first_next = first_reg; jj_next = jj_reg;
        jend_next = jend_reg;   acc_next = acc_reg;
        vn_next = vn_reg;       vd_next = vd_reg;
        r_next = r_reg;         c_next = c_reg;
        pos_next = pos_reg;
        rv_next = 1'b0;         status_next = status_reg;
        pn_next = pn_reg;       ip_next = ip_reg;

        edge_we = 1'b0; edge_wa = ecnt_reg[EI_W-1:0]; edge_wd = {row_index, col_index};
        edge_ra = k_reg[EI_W-1:0];
        deg_we = 1'b0;  deg_wa = '0; deg_wd = '0; deg_ra = '0;
        rs_we = 1'b0;   rs_wa = '0;  rs_wd = '0;  rs_ra = '0;
        fill_we = 1'b0; fill_wa = '0; fill_wd = '0; fill_ra = '0;
        nbr_we = 1'b0;  nbr_wa = '0; nbr_wd = '0; nbr_ra = jj_reg[NB_W-1:0];
        vis_we = 1'b0;  vis_wa = '0; vis_wd = 1'b0; vis_ra = '0;
        srt_we = 1'b0;  srt_wa = j_reg[NI_W-1:0]; srt_wd = '0; srt_ra = '0;
        walk_we = 1'b0; walk_wa = j_reg[NI_W-1:0]; walk_wd = '0; walk_ra = '0;
        new_we = 1'b0;  new_wa = i_reg[NI_W-1:0]; new_wd = i_reg[NI_W-1:0];
        inv_we = 1'b0;  inv_wa = i_reg[NI_W-1:0]; inv_wd = i_reg[NI_W-1:0];

        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_NODE_COUNT: nc_next = cfg_data;
                REG_PINNED:     pc_next = cfg_data[NODE_W-1:0];
                default:        nc_next = nc_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
                if (acc_item)
                begin
                    pn_next = '0;
                    ip_next = '0;
                    status_next = ST_OK;
                    unique case (cmd)
                        CMD_LOAD:
                        begin
                            rv_next = 1'b1;
                            if (32'(ecnt_reg) < MAX_EDGES)
                            begin
                                edge_we = 1'b1;
                                ecnt_next = ecnt_reg + EC_W'(1);
                            end
                            else status_next = ST_FULL;
                        end
                        CMD_RUN:
                            if (cfg_bad)
                            begin
                                rv_next = 1'b1;
                                status_next = ST_BAD;
                                ready_next = 1'b0;
                            end
                            else
                            begin
                                dim_next = CNT_W'(nc_reg - {1'b0, pc_reg});
                                i_next = '0;
                            end
                        CMD_READ:
                            if (!ready_reg)
                            begin
                                rv_next = 1'b1;
                                status_next = ST_NORES;
                            end
                            else pos_next = position;
                        CMD_NOP: rv_next = 1'b1;
                        default: rv_next = 1'b1;
                    endcase
                end
            S_READ:
            begin
                rv_next = 1'b1;
                status_next = ST_OK;
                if (32'(pos_reg) < MAX_NODES)
                begin
                    pn_next = NODE_W'(new_rd);
                    ip_next = NODE_W'(inv_rd);
                end
                else
                begin
                    pn_next = pos_reg;
                    ip_next = pos_reg;
                end
            end
            S_CLR:
            begin
                deg_we = 1'b1; deg_wa = i_reg[NI_W-1:0];
                vis_we = 1'b1; vis_wa = i_reg[NI_W-1:0];
                rs_we = 1'b1;  rs_wa = i_reg;
                i_next = i_reg + CNT_W'(1);
                k_next = '0;
            end
            S_CNT_RD:
            begin
                i_next = '0;
                acc_next = '0;
            end
            S_CNT_R:
            begin
                r_next = NI_W'(e_r);
                c_next = NI_W'(e_c);
                deg_ra = NI_W'(e_r);
                if (!e_ok) k_next = k_reg + EC_W'(1);
            end
            S_CNT_WR:
            begin
                deg_we = 1'b1; deg_wa = r_reg; deg_wd = deg_rd + RS_W'(1);
                deg_ra = c_reg;
            end
            S_CNT_WC:
            begin
                deg_we = 1'b1; deg_wa = c_reg; deg_wd = deg_rd + RS_W'(1);
                k_next = k_reg + EC_W'(1);
            end
            S_PFX_RD:
            begin
                deg_ra = i_reg[NI_W-1:0];
                k_next = '0;
            end
            S_PFX_WR:
            begin
                rs_we = 1'b1; rs_wa = i_reg + CNT_W'(1); rs_wd = acc_reg + deg_rd;
                fill_we = 1'b1; fill_wa = i_reg[NI_W-1:0]; fill_wd = acc_reg;
                acc_next = acc_reg + deg_rd;
                i_next = i_reg + CNT_W'(1);
            end
            S_FIL_RD: i_next = '0;
            S_FIL_R:
            begin
                r_next = NI_W'(e_r);
                c_next = NI_W'(e_c);
                fill_ra = NI_W'(e_r);
                if (!e_ok) k_next = k_reg + EC_W'(1);
            end
            S_FIL_WR:
            begin
                nbr_we = 1'b1; nbr_wa = fill_rd[NB_W-1:0]; nbr_wd = c_reg;
                fill_we = 1'b1; fill_wa = r_reg; fill_wd = fill_rd + RS_W'(1);
                fill_ra = c_reg;
            end
            S_FIL_WC:
            begin
                nbr_we = 1'b1; nbr_wa = fill_rd[NB_W-1:0]; nbr_wd = r_reg;
                fill_we = 1'b1; fill_wa = c_reg; fill_wd = fill_rd + RS_W'(1);
                k_next = k_reg + EC_W'(1);
            end
            S_SRT_RD:
            begin
                deg_ra = i_reg[NI_W-1:0];
                z_next = '0;
                cnt_next = '0;
                ii_next = '0;
            end
            S_SRT_K:
            begin
                vn_next = i_reg[NI_W-1:0];
                vd_next = deg_rd;
                j_next = i_reg;
                srt_ra = jm1_of_i(i_reg);
                if (i_reg == '0)
                begin
                    srt_we = 1'b1; srt_wa = '0; srt_wd = {i_reg[NI_W-1:0], deg_rd};
                    i_next = i_reg + CNT_W'(1);
                end
            end
            S_SRT_CMP:
                if (srt_less)
                begin
                    srt_we = 1'b1; srt_wd = srt_rd;
                    j_next = jm1;
                    srt_ra = jm2[NI_W-1:0];
                end
                else
                begin
                    srt_we = 1'b1; srt_wd = {vn_reg, vd_reg};
                    i_next = i_reg + CNT_W'(1);
                end
            S_SRT_PUT:
            begin
                srt_we = 1'b1; srt_wd = {vn_reg, vd_reg};
                i_next = i_reg + CNT_W'(1);
            end
            S_SEED_RD:
            begin
                srt_ra = z_reg[NI_W-1:0];
                i_next = '0;
            end
            S_SEED_V:
            begin
                vn_next = srt_rd[PW-1:RS_W];
                vd_next = srt_rd[RS_W-1:0];
                vis_ra = srt_rd[PW-1:RS_W];
            end
            S_SEED_CHK:
            begin
                z_next = z_reg + CNT_W'(1);
                if (!vis_rd)
                begin
                    vis_we = 1'b1; vis_wa = vn_reg; vis_wd = 1'b1;
                    walk_we = 1'b1; walk_wa = cnt_reg[NI_W-1:0]; walk_wd = {vn_reg, vd_reg};
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_NODE_RD: walk_ra = ii_reg[NI_W-1:0];
            S_NODE_RS0:
            begin
                vn_next = walk_rd[PW-1:RS_W];
                rs_ra = CNT_W'(walk_rd[PW-1:RS_W]);
            end
            S_NODE_RS1:
            begin
                jj_next = rs_rd;
                rs_ra = CNT_W'(vn_reg) + CNT_W'(1);
            end
            S_NODE_RS2:
            begin
                jend_next = rs_rd;
                first_next = cnt_reg;
            end
            S_NB_RD: a_next = first_reg + CNT_W'(1);
            S_NB_V:
            begin
                r_next = nbr_rd;
                vis_ra = nbr_rd;
            end
            S_NB_CHK:
            begin
                deg_ra = r_reg;
                if (vis_rd) jj_next = jj_reg + RS_W'(1);
                else
                begin
                    vis_we = 1'b1; vis_wa = r_reg; vis_wd = 1'b1;
                end
            end
            S_NB_DEG:
            begin
                walk_we = 1'b1; walk_wa = cnt_reg[NI_W-1:0]; walk_wd = {r_reg, deg_rd};
                cnt_next = cnt_reg + CNT_W'(1);
                jj_next = jj_reg + RS_W'(1);
            end
            S_WS_A:
            begin
                walk_ra = a_reg[NI_W-1:0];
                if (!(a_reg < cnt_reg)) ii_next = ii_reg + CNT_W'(1);
            end
            S_WS_V:
            begin
                vn_next = walk_rd[PW-1:RS_W];
                vd_next = walk_rd[RS_W-1:0];
                j_next = a_reg;
                walk_ra = jm1_of_i(a_reg);
            end
            S_WS_CMP:
                if (ws_less)
                begin
                    walk_we = 1'b1; walk_wd = walk_rd;
                    j_next = jm1;
                    walk_ra = jm2[NI_W-1:0];
                end
                else
                begin
                    walk_we = 1'b1; walk_wd = {vn_reg, vd_reg};
                    a_next = a_reg + CNT_W'(1);
                end
            S_WS_PUT:
            begin
                walk_we = 1'b1; walk_wd = {vn_reg, vd_reg};
                a_next = a_reg + CNT_W'(1);
            end
            S_OUT_RD:
            begin
                walk_ra = dmi[NI_W-1:0];
                if (32'(i_reg) == MAX_NODES)
                begin
                    ready_next = 1'b1;
                    rv_next = 1'b1;
                    status_next = ST_OK;
                    pn_next = '0;
                    ip_next = '0;
                end
                else if (!(i_reg < dim_reg))
                begin
                    // pinned and unused nodes map to themselves
                    new_we = 1'b1;
                    inv_we = 1'b1;
                    i_next = i_reg + CNT_W'(1);
                end
            end
            S_OUT_WR:
            begin
                new_we = 1'b1; new_wd = walk_rd[PW-1:RS_W];
                inv_we = 1'b1; inv_wa = walk_rd[PW-1:RS_W];
                i_next = i_reg + CNT_W'(1);
            end
            default: rv_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            nc_reg     <= CFG_W'(256);
            pc_reg     <= '0;
            ecnt_reg   <= '0;
            ready_reg  <= 1'b0;
            dim_reg    <= '0;
            k_reg      <= '0;
            i_reg      <= '0;
            j_reg      <= '0;
            z_reg      <= '0;
            cnt_reg    <= '0;
            ii_reg     <= '0;
            a_reg      <= '0;
            first_reg  <= '0;
            jj_reg     <= '0;
            jend_reg   <= '0;
            acc_reg    <= '0;
            rv_reg     <= 1'b0;
            status_reg <= ST_OK;
            pn_reg     <= '0;
            ip_reg     <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            nc_reg     <= nc_next;
            pc_reg     <= pc_next;
            ecnt_reg   <= ecnt_next;
            ready_reg  <= ready_next;
            dim_reg    <= dim_next;
            k_reg      <= k_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            z_reg      <= z_next;
            cnt_reg    <= cnt_next;
            ii_reg     <= ii_next;
            a_reg      <= a_next;
            first_reg  <= first_next;
            jj_reg     <= jj_next;
            jend_reg   <= jend_next;
            acc_reg    <= acc_next;
            rv_reg     <= rv_next;
            status_reg <= status_next;
            pn_reg     <= pn_next;
            ip_reg     <= ip_next;
        end
    end

    // payload registers, not reset
    always_ff @(posedge clk)
    begin
        vn_reg  <= vn_next;
        vd_reg  <= vd_next;
        r_reg   <= r_next;
        c_reg   <= c_next;
        pos_reg <= pos_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = rv_reg;
    assign status       = status_reg;
    assign perm_node    = pn_reg;
    assign inverse_pos  = ip_reg;

    // ---------------- assertions ----------------
    `RCM_ASSERT_NXT(a_load_answers, clk, rst_n, acc_item && cmd == CMD_LOAD, result_valid && !busy)
    `RCM_ASSERT_NXT(a_run_goes_busy, clk, rst_n, acc_item && cmd == CMD_RUN && !cfg_bad, busy)
    `RCM_ASSERT_IMP(a_queue_order, clk, rst_n, 1'b1, ii_reg <= cnt_reg)
    `RCM_ASSERT_IMP(a_queue_bound, clk, rst_n, state_reg == S_NODE_RD, cnt_reg <= dim_reg)
    `RCM_ASSERT_NXT(a_run_done, clk, rst_n, state_reg == S_OUT_RD && 32'(i_reg) == MAX_NODES,
                    result_valid && status == ST_OK && !busy)

endmodule
`default_nettype wire

>>> dv/tb_reverse_cuthill_mckee_order_core.sv
// Testbench for the reverse Cuthill-McKee ordering core: table-driven and random commands.
`timescale 1ns / 1ps
module tb_reverse_cuthill_mckee_order_core;
    import rcm_pkg::*;

    localparam int MAX_NODES  = 256;
    localparam int MAX_EDGES  = 1024;
    // The stall limit is taken well above a full run over a packed edge store.
    localparam int STALL_LIMIT = 400000;
    localparam int PHASE_ITEMS = 317;

    // Row kinds of the directed table.
    localparam logic ROW_CMD = 1'b0;
    localparam logic ROW_CFG = 1'b1;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [CMD_W-1:0]    cmd;
    logic [NODE_W-1:0]   row_index;
    logic [NODE_W-1:0]   col_index;
    logic [NODE_W-1:0]   position;
    logic                result_valid;
    logic [STATUS_W-1:0] status;
    logic [NODE_W-1:0]   perm_node;
    logic [NODE_W-1:0]   inverse_pos;
    logic                cfg_valid;
    logic                cfg_ready;
    logic                cfg_index;
    logic [CFG_W-1:0]    cfg_data;

    reverse_cuthill_mckee_order_core #(
        .MAX_NODES(MAX_NODES),
        .MAX_EDGES(MAX_EDGES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .row_index(row_index),
        .col_index(col_index),
        .position(position),
        .result_valid(result_valid),
        .status(status),
        .perm_node(perm_node),
        .inverse_pos(inverse_pos),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // One expected result beat.
    typedef struct packed {
        logic [STATUS_W-1:0] st;
        logic [NODE_W-1:0]   pn;
        logic [NODE_W-1:0]   ip;
    } order_reply_t;

    // One directed stimulus row; the typed reply is used only where has_reply is set.
    typedef struct {
        logic             kind;
        logic [CMD_W-1:0] op;
        logic [7:0]       a;
        logic [7:0]       b;
        logic [7:0]       pos;
        logic [CFG_W-1:0] data;
        bit               has_reply;
        order_reply_t     reply;
    } stim_row_t;

    order_reply_t pending_replies[$];

    // Shadow state of the ordering engine.
    logic [8:0] sh_node_count;
    logic [7:0] sh_pinned;
    logic [7:0] sh_erow [MAX_EDGES];
    logic [7:0] sh_ecol [MAX_EDGES];
    int         sh_ecount;
    bit         sh_ready;
    logic [7:0] sh_perm [MAX_NODES];
    logic [7:0] sh_inv  [MAX_NODES];

    int  fail_count;
    int  stall_cycles;
    int  n_loads, n_runs, n_reads, n_full, n_bad;
    int  idle_pct;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Rebuild the ordering the way the engine does: CSR adjacency, degree sort
    // with ties kept in index order, BFS with per-node insertion sort, reversal.
    function automatic void compute_ordering(int dim);
        int rs   [MAX_NODES+1];
        int fillp[MAX_NODES];
        int nbl  [2*MAX_EDGES];
        int deg  [MAX_NODES];
        bit vis  [MAX_NODES];
        int srt  [MAX_NODES];
        int wk   [MAX_NODES];
        int cnt, lo, hi, seed, node, first, v, j, r, c;
        for (int i = 0; i <= MAX_NODES; i++) rs[i] = 0;
        for (int i = 0; i < MAX_NODES; i++)
        begin
            deg[i] = 0;
            vis[i] = 0;
        end
        for (int k = 0; k < sh_ecount; k++)
        begin
            r = sh_erow[k];
            c = sh_ecol[k];
            if (r < dim && c < dim && r != c)
            begin
                rs[r+1]++;
                rs[c+1]++;
            end
        end
        for (int i = 1; i <= dim; i++) rs[i] += rs[i-1];
        for (int i = 0; i < dim; i++) fillp[i] = rs[i];
        for (int k = 0; k < sh_ecount; k++)
        begin
            r = sh_erow[k];
            c = sh_ecol[k];
            if (r < dim && c < dim && r != c)
            begin
                nbl[fillp[r]++] = c;
                nbl[fillp[c]++] = r;
            end
        end
        for (int i = 0; i < dim; i++) deg[i] = rs[i+1] - rs[i];
        // strict compare keeps equal degrees in ascending node order
        for (int i = 0; i < dim; i++)
        begin
            j = i;
            while (j > 0 && deg[i] < deg[srt[j-1]])
            begin
                srt[j] = srt[j-1];
                j--;
            end
            srt[j] = i;
        end
        cnt = 0;
        for (int z = 0; z < dim; z++)
        begin
            seed = srt[z];
            if (!vis[seed])
            begin
                vis[seed] = 1;
                wk[cnt++] = seed;
                lo = cnt - 1;
                hi = cnt;
                while (lo < hi)
                begin
                    for (int ii = lo; ii < hi; ii++)
                    begin
                        node  = wk[ii];
                        first = cnt;
                        for (int jj = rs[node]; jj < rs[node+1]; jj++)
                        begin
                            if (!vis[nbl[jj]])
                            begin
                                vis[nbl[jj]] = 1;
                                wk[cnt++] = nbl[jj];
                            end
                        end
                        for (int a = first + 1; a < cnt; a++)
                        begin
                            v = wk[a];
                            j = a;
                            while (j > first && deg[v] < deg[wk[j-1]])
                            begin
                                wk[j] = wk[j-1];
                                j--;
                            end
                            wk[j] = v;
                        end
                    end
                    lo = hi;
                    hi = cnt;
                end
            end
        end
        for (int k = 0; k < MAX_NODES; k++)
            sh_perm[k] = 8'((k < dim) ? wk[dim-1-k] : k);
        for (int k = 0; k < MAX_NODES; k++)
            sh_inv[sh_perm[k]] = 8'(k);
        sh_ready = 1;
    endfunction

    // Expected reply of one command beat; updates the shadow state.
    function automatic order_reply_t predict_reply(logic [CMD_W-1:0] op, logic [7:0] r,
                                                   logic [7:0] c, logic [7:0] p);
        order_reply_t rep;
        rep = '0;
        case (op)
            CMD_LOAD:
            begin
                if (sh_ecount < MAX_EDGES)
                begin
                    sh_erow[sh_ecount] = r;
                    sh_ecol[sh_ecount] = c;
                    sh_ecount++;
                end
                else
                    rep.st = ST_FULL;
            end
            CMD_RUN:
            begin
                if (sh_node_count == 0 || sh_node_count > MAX_NODES
                    || sh_pinned >= sh_node_count)
                begin
                    rep.st   = ST_BAD;
                    sh_ready = 0;
                end
                else
                    compute_ordering(sh_node_count - sh_pinned);
            end
            CMD_READ:
            begin
                if (!sh_ready)
                    rep.st = ST_NORES;
                else
                begin
                    rep.pn = sh_perm[p];
                    rep.ip = sh_inv[p];
                end
            end
            default: ;
        endcase
        return rep;
    endfunction

    // Drive one command beat, wait for it to be taken, queue its reply,
    // then maybe let the sender go quiet for a while.
    task automatic send_cmd(logic [CMD_W-1:0] op, logic [7:0] r, logic [7:0] c,
                            logic [7:0] p, bit has_reply, order_reply_t typed);
        order_reply_t rep;
        @(negedge clk);
        start     = 1'b1;
        cmd       = op;
        row_index = r;
        col_index = c;
        position  = p;
        forever
        begin
            @(posedge clk);
            if (!busy) break;
        end
        rep = predict_reply(op, r, c, p);
        pending_replies.push_back(has_reply ? typed : rep);
        case (op)
            CMD_LOAD: begin n_loads++; if (rep.st == ST_FULL) n_full++; end
            CMD_RUN:  begin n_runs++;  if (rep.st == ST_BAD)  n_bad++;  end
            CMD_READ: n_reads++;
            default: ;
        endcase
        if ($urandom_range(0, 99) < idle_pct)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge clk);
        end
    endtask

    // Hold off until every queued reply has come and the engine is quiet.
    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        while (pending_replies.size() != 0 || busy) @(posedge clk);
    endtask

    // Register write; only issued once the engine has drained.
    task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
        drain();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        forever
        begin
            @(posedge clk);
            if (cfg_ready) break;
        end
        if (idx == REG_NODE_COUNT) sh_node_count = val;
        else                       sh_pinned     = val[7:0];
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Reply checker: every result beat must match the oldest queued reply.
    always @(posedge clk)
    begin
        order_reply_t exp_rep;
        if (rst_n && result_valid)
        begin
            if (pending_replies.size() == 0)
            begin
                $error("result beat with no reply pending: status %0d", status);
                fail_count++;
            end
            else
            begin
                exp_rep = pending_replies.pop_front();
                if (status !== exp_rep.st)
                begin
                    $error("status: expected %0d, got %0d", exp_rep.st, status);
                    fail_count++;
                end
                if (perm_node !== exp_rep.pn)
                begin
                    $error("perm_node: expected %0d, got %0d", exp_rep.pn, perm_node);
                    fail_count++;
                end
                if (inverse_pos !== exp_rep.ip)
                begin
                    $error("inverse_pos: expected %0d, got %0d", exp_rep.ip, inverse_pos);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: counts cycles where no beat moves on any channel.
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb_reverse_cuthill_mckee_order_core failed");
            $finish;
        end
    end

    // Main sequence.
    initial
    begin
        stim_row_t    dir_rows[$];
        order_reply_t rz;
        int           dim, rv;
        logic [7:0]   ra, rb, rp;
        int           phase_nodes [6];
        int           phase_pins  [6];

        start = 1'b0;  cmd = CMD_NOP;  row_index = '0;  col_index = '0;  position = '0;
        cfg_valid = 1'b0;  cfg_index = REG_NODE_COUNT;  cfg_data = '0;
        rst_n = 1'b0;
        fail_count = 0;  stall_cycles = 0;  idle_pct = 0;
        n_loads = 0;  n_runs = 0;  n_reads = 0;  n_full = 0;  n_bad = 0;
        sh_node_count = 9'd256;  sh_pinned = 8'd0;  sh_ecount = 0;  sh_ready = 0;
        rz = '0;

        // Directed table. Typed replies only where they are obvious.
        dir_rows = '{
            '{ROW_CMD, CMD_READ, 0,   0,   0,   0, 1, '{ST_NORES, 8'd0, 8'd0}},
            '{ROW_CMD, CMD_NOP,  255, 255, 255, 0, 1, '{ST_OK, 8'd0, 8'd0}},
            '{ROW_CMD, CMD_LOAD, 0,   255, 0,   0, 1, '{ST_OK, 8'd0, 8'd0}},
            '{ROW_CMD, CMD_LOAD, 255, 0,   0,   0, 1, '{ST_OK, 8'd0, 8'd0}},
            '{ROW_CMD, CMD_LOAD, 3,   3,   0,   0, 1, '{ST_OK, 8'd0, 8'd0}},  // self-loop
            '{ROW_CMD, CMD_LOAD, 1,   2,   0,   0, 0, '{ST_OK, 8'd0, 8'd0}},
            '{ROW_CMD, CMD_LOAD, 1,   2,   0,   0, 0, '{ST_OK, 8'd0, 8'd0}},  // duplicate
            '{ROW_CMD, CMD_LOAD, 2,   4,   0,   0, 0, '{ST_OK, 8'd0, 8'd0}},
            '{ROW_CMD, CMD_RUN,  0,   0,   0,   0, 0, '{ST_OK, 8'd0, 8'd0}},
            '{ROW_CMD, CMD_READ, 0,   0,   0,   0, 0, '{ST_OK, 8'd0, 8'd0}},
            '{ROW_CMD, CMD_READ, 0,   0,   255, 0, 0, '{ST_OK, 8'd0, 8'd0}},
            '{ROW_CFG, CMD_NOP,  0,   0,   0,   0, 0, '{ST_OK, 8'd0, 8'd0}},  // node_count 0
            '{ROW_CMD, CMD_READ, 0,   0,   2,   0, 0, '{ST_OK, 8'd0, 8'd0}},  // old result kept
            '{ROW_CMD, CMD_RUN,  0,   0,   0,   0, 1, '{ST_BAD, 8'd0, 8'd0}},
            '{ROW_CMD, CMD_READ, 0,   0,   2,   0, 1, '{ST_NORES, 8'd0, 8'd0}},
            '{ROW_CFG, CMD_NOP,  0,   0,   0, 511, 0, '{ST_OK, 8'd0, 8'd0}},
            '{ROW_CMD, CMD_RUN,  0,   0,   0,   0, 1, '{ST_BAD, 8'd0, 8'd0}},
            '{ROW_CFG, CMD_NOP,  0,   0,   0,   8, 0, '{ST_OK, 8'd0, 8'd0}},
            '{ROW_CFG, CMD_NOP,  1,   0,   0,   8, 0, '{ST_OK, 8'd0, 8'd0}},  // pinned == count
            '{ROW_CMD, CMD_RUN,  0,   0,   0,   0, 1, '{ST_BAD, 8'd0, 8'd0}},
            '{ROW_CFG, CMD_NOP,  1,   0,   0,   3, 0, '{ST_OK, 8'd0, 8'd0}},
            '{ROW_CMD, CMD_RUN,  0,   0,   0,   0, 0, '{ST_OK, 8'd0, 8'd0}},
            '{ROW_CMD, CMD_READ, 0,   0,   4,   0, 0, '{ST_OK, 8'd0, 8'd0}},
            '{ROW_CMD, CMD_READ, 0,   0,   200, 0, 1, '{ST_OK, 8'd200, 8'd200}},
            '{ROW_CFG, CMD_NOP,  0,   0,   0, 256, 0, '{ST_OK, 8'd0, 8'd0}},
            '{ROW_CFG, CMD_NOP,  1,   0,   0, 255, 0, '{ST_OK, 8'd0, 8'd0}},  // one active node
            '{ROW_CMD, CMD_RUN,  0,   0,   0,   0, 0, '{ST_OK, 8'd0, 8'd0}},
            '{ROW_CMD, CMD_READ, 0,   0,   255, 0, 1, '{ST_OK, 8'd255, 8'd255}}
        };

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part, no sender gaps
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
                write_reg(dir_rows[i].a[0], dir_rows[i].data);
            else
                send_cmd(dir_rows[i].op, dir_rows[i].a, dir_rows[i].b, dir_rows[i].pos,
                         dir_rows[i].has_reply, dir_rows[i].reply);
        end

        // Random phases: gaps 19% for two phases, 66% for two, then none.
        phase_nodes = '{256, 16, 64, 2, 200, 256};
        phase_pins  = '{0,   0,  8,  1, 100, 0};
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(REG_NODE_COUNT, CFG_W'(phase_nodes[ph]));
            write_reg(REG_PINNED, CFG_W'(phase_pins[ph]));
            idle_pct = (ph < 2) ? 19 : (ph < 4) ? 66 : 0;
            dim = phase_nodes[ph] - phase_pins[ph];
            send_cmd(CMD_RUN, 0, 0, 0, 0, rz);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // sender holds off once per phase until the engine has drained
                if (n == PHASE_ITEMS / 2) drain();
                rv = $urandom_range(0, 99);
                if ($urandom_range(0, 4) != 0)
                begin
                    ra = 8'($urandom_range(0, (dim + 1 > 255) ? 255 : dim + 1));
                    rb = 8'($urandom_range(0, (dim + 1 > 255) ? 255 : dim + 1));
                    rp = 8'($urandom_range(0, dim - 1));
                end
                else
                begin
                    ra = 8'($urandom);
                    rb = 8'($urandom);
                    rp = 8'($urandom);
                end
                if (rv < 55)      send_cmd(CMD_LOAD, ra, rb, rp, 0, rz);
                else if (rv < 57) send_cmd(CMD_RUN,  ra, rb, rp, 0, rz);
                else if (rv < 95) send_cmd(CMD_READ, ra, rb, rp, 0, rz);
                else              send_cmd(CMD_NOP,  ra, rb, rp, 0, rz);
            end
        end

        drain();
        repeat (20) @(posedge clk);

        $display("covered %0d loads (%0d refused as full), %0d runs (%0d rejected), %0d reads",
                 n_loads, n_full, n_runs, n_bad, n_reads);
        if (fail_count == 0 && pending_replies.size() == 0)
            $display("tb_reverse_cuthill_mckee_order_core passed");
        else
            $display("tb_reverse_cuthill_mckee_order_core failed");
        $finish;
    end

endmodule

>>> reverse_cuthill_mckee_order_core.f
+incdir+rtl
rtl/rcm_pkg.sv
rtl/reverse_cuthill_mckee_order_core.sv
dv/tb_reverse_cuthill_mckee_order_core.sv
